// ===== sv/arfv_pkg.sv =====
// package for the audio ring fifo with volume
// shared constants, request codes and the pipeline slot type; no dependencies
package arfv_pkg;

    localparam int RING_DEPTH  = 8192;
    localparam int ADDR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SAMPLE_BITS = 16;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 15;
    localparam int CFG_IDX_W   = 8;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(32768);

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_PULL  = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE = CFG_IDX_W'(1);

    // what one accepted request left for the output side
    typedef struct packed {
        logic hit;       // pull that reads the ring
        logic underrun;
        logic accepted;
    } t_slot;

endpackage

// ===== sv/arfv_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module arfv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/arfv_ctrl.sv =====
// ring pointer and flush control: decides each request and issues ram accesses
// depends on arfv_pkg
module arfv_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_take,
    input  logic [1:0]                      i_req_type,
    input  logic [arfv_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic                            i_block_start,
    output logic                            o_we,
    output logic [arfv_pkg::ADDR_W-1:0]     o_waddr,
    output logic [arfv_pkg::SAMPLE_BITS-1:0] o_wdata,
    output logic [arfv_pkg::ADDR_W-1:0]     o_raddr,
    output arfv_pkg::t_slot                 o_slot
);
    import arfv_pkg::*;

    logic [CNT_W-1:0] r_wr, n_wr;
    logic [CNT_W-1:0] r_rd, n_rd;
    logic             r_flush, n_flush;
    logic             r_silenced, n_silenced;

    logic [CNT_W-1:0] w_used;
    logic [CNT_W-1:0] w_rd_eff;
    logic             w_sil_eff;
    logic             w_flush_eff;
    t_req             w_req;

    assign w_req  = t_req'(i_req_type);
    // used never exceeds the depth, so its top bit means full
    assign w_used = r_wr - r_rd;

    always_comb begin
        w_rd_eff    = r_rd;
        w_sil_eff   = r_silenced;
        w_flush_eff = r_flush;
        if (i_block_start) begin
            w_sil_eff = r_flush;
            if (r_flush) begin
                w_rd_eff    = r_wr;
                w_flush_eff = 1'b0;
            end
        end
    end

    always_comb begin
        n_wr       = r_wr;
        n_rd       = r_rd;
        n_flush    = r_flush;
        n_silenced = r_silenced;
        o_we       = 1'b0;
        o_slot     = '0;
        unique case (w_req)
            REQ_PUSH: begin
                if (!w_used[ADDR_W]) begin
                    o_we            = i_take;
                    o_slot.accepted = 1'b1;
                    n_wr            = r_wr + CNT_W'(1);
                end
            end
            REQ_PULL: begin
                n_flush    = w_flush_eff;
                n_silenced = w_sil_eff;
                n_rd       = w_rd_eff;
                if (w_sil_eff || (w_rd_eff == r_wr)) begin
                    o_slot.underrun = 1'b1;
                end else begin
                    o_slot.hit = 1'b1;
                    n_rd       = w_rd_eff + CNT_W'(1);
                end
            end
            REQ_FLUSH: begin
                n_flush = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_waddr = r_wr[ADDR_W-1:0];
    assign o_wdata = i_sample_in;
    assign o_raddr = w_rd_eff[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr       <= '0;
            r_rd       <= '0;
            r_flush    <= 1'b0;
            r_silenced <= 1'b0;
        end else if (i_take) begin
            r_wr       <= n_wr;
            r_rd       <= n_rd;
            r_flush    <= n_flush;
            r_silenced <= n_silenced;
        end
    end

endmodule

// ===== sv/arfv_out.sv =====
// output side: read-data slot, gain multiply and result register with flow control
// depends on arfv_pkg
module arfv_out (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_take,
    input  arfv_pkg::t_slot                  i_slot,
    input  logic [arfv_pkg::SAMPLE_BITS-1:0] i_rdata,
    input  logic [arfv_pkg::GAIN_W-1:0]      i_gain,
    input  logic                             i_mute,
    input  logic                             i_out_stall,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output logic [arfv_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                             o_underrun,
    output logic                             o_push_accepted
);
    import arfv_pkg::*;

    logic  r_s1_valid;
    t_slot r_s1;
    logic  r_out_valid;
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic  r_underrun;
    logic  r_accepted;

    logic  w_s2_load;
    logic  w_s1_free;
    logic signed [GAIN_W:0]             w_gain_s;
    logic signed [SAMPLE_BITS+GAIN_W:0] w_prod;

    assign w_s2_load = !r_out_valid || !i_out_stall;
    assign w_s1_free = !r_s1_valid || w_s2_load;
    assign o_take    = i_in_valid && w_s1_free;
    assign o_in_stall = !w_s1_free;

    // mute is just a zero gain; the register already holds at most unity
    assign w_gain_s = i_mute ? '0 : signed'({1'b0, i_gain});
    assign w_prod   = signed'(i_rdata) * w_gain_s;

    always_comb begin
        n_sample = '0;
        if (r_s1.hit) begin
            n_sample = w_prod[GAIN_FRAC+SAMPLE_BITS-1:GAIN_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_s2_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_s1 <= i_slot;
        end
        if (w_s2_load && r_s1_valid) begin
            r_sample   <= n_sample;
            r_underrun <= r_s1.underrun;
            r_accepted <= r_s1.accepted;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample_out    = r_sample;
    assign o_underrun      = r_underrun;
    assign o_push_accepted = r_accepted;

    a_stall_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with free pipeline");

    a_slot_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> ($countones({r_s1.hit, r_s1.underrun, r_s1.accepted}) <= 1))
        else $error("slot carries more than one outcome");

    a_underrun_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_underrun || r_accepted)) |-> (r_sample == '0))
        else $error("nonzero sample on underrun or push result");

    a_result_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_out_valid) |=> r_out_valid)
        else $error("slot did not move into empty result register");

endmodule

// ===== sv/audio_ring_fifo_with_volume_top.sv =====
// top level of the audio ring fifo with volume: config registers and instances
// depends on arfv_pkg, arfv_ram, arfv_ctrl, arfv_out
//
// Mono playback FIFO over an 8192-entry ring of signed 16-bit samples. Each request
// (push, pull, flush) is taken back to back while o_in_stall is low and gives one
// result: taking it updates the pointers and reads or writes the sample ram (one
// write port and one registered read port), then the result register takes the read
// sample scaled by the unsigned Q1.15 gain. A full ring drops a push, an empty ring
// or a block silenced by a flush makes a pull return zero with underrun. Gain writes
// above 32768 saturate to unity. The sample ram is not cleared at reset; only
// entries already pushed are ever read. Configuration is taken at any time on a
// one-cycle write and should only change while no request is in flight.
module audio_ring_fifo_with_volume_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_req_type,
    input  logic [arfv_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic                             i_block_start,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [arfv_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                             o_underrun,
    output logic                             o_push_accepted,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [arfv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [arfv_pkg::GAIN_W-1:0]      i_cfg_data
);
    import arfv_pkg::*;

    logic [GAIN_W-1:0]      r_gain;
    logic                   r_mute;
    logic                   w_take;
    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr;
    logic [ADDR_W-1:0]      w_raddr;
    logic [SAMPLE_BITS-1:0] w_wdata;
    logic [SAMPLE_BITS-1:0] w_rdata;
    t_slot                  w_slot;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_ONE;
            r_mute <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_GAIN) begin
                r_gain <= (i_cfg_data > GAIN_ONE) ? GAIN_ONE : i_cfg_data;
            end
            if (i_cfg_index == CFG_MUTE) begin
                r_mute <= i_cfg_data[0];
            end
        end
    end

    arfv_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_take),
        .i_req_type    (i_req_type),
        .i_sample_in   (i_sample_in),
        .i_block_start (i_block_start),
        .o_we          (w_we),
        .o_waddr       (w_waddr),
        .o_wdata       (w_wdata),
        .o_raddr       (w_raddr),
        .o_slot        (w_slot)
    );

    arfv_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_take && w_slot.hit),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    arfv_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_take          (w_take),
        .i_slot          (w_slot),
        .i_rdata         (w_rdata),
        .i_gain          (r_gain),
        .i_mute          (r_mute),
        .i_out_stall     (i_out_stall),
        .o_in_stall      (o_in_stall),
        .o_out_valid     (o_out_valid),
        .o_sample_out    (o_sample_out),
        .o_underrun      (o_underrun),
        .o_push_accepted (o_push_accepted)
    );

endmodule

// ===== test/tb_audio_ring_fifo_with_volume_top.sv =====
// testbench for audio_ring_fifo_with_volume_top: directed table and random traffic
// depends on arfv_pkg and the block's rtl; checks each result with a typed row or ring predictor
`timescale 1ns / 1ps

module tb_audio_ring_fifo_with_volume_top;
    import arfv_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(2);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   underrun;
        logic                   accepted;
    } t_result;

    typedef struct packed {
        t_req                   req;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   blk_start;
        logic                   typed;
        t_result                res;
    } t_row;

    typedef enum int {STALL_OFF, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} t_stall_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [1:0]             i_req_type;
    logic [SAMPLE_BITS-1:0] i_sample_in;
    logic                   i_block_start;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [SAMPLE_BITS-1:0] o_sample_out;
    logic                   o_underrun;
    logic                   o_push_accepted;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [GAIN_W-1:0]      i_cfg_data;

    audio_ring_fifo_with_volume_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_sample_in     (i_sample_in),
        .i_block_start   (i_block_start),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sample_out    (o_sample_out),
        .o_underrun      (o_underrun),
        .o_push_accepted (o_push_accepted),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // predictor copy of the ring and its registers
    logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
    logic [CNT_W-1:0]       wr_cnt;
    logic [CNT_W-1:0]       rd_cnt;
    logic                   flush_pend;
    logic                   silenced;
    logic [GAIN_W-1:0]      gain_q15;
    logic                   mute_on;

    t_result awaited_results [$];
    t_row    dir_rows [$];

    int mismatch_cnt;
    int burst_left;
    int blk_left;
    int n_push, n_pull, n_flush, n_noop, n_drop, n_under, n_cfg;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results still awaited", awaited_results.size());
        $display("tb_audio_ring_fifo_with_volume_top NOT OK");
        $finish;
    end

    function automatic logic [SAMPLE_BITS-1:0] scale_by_gain(logic signed [SAMPLE_BITS-1:0] s,
                                                             logic [GAIN_W-1:0] g);
        logic signed [SAMPLE_BITS+GAIN_W:0] prod;
        prod = s * $signed({1'b0, g});
        prod = prod >>> GAIN_FRAC;
        return prod[SAMPLE_BITS-1:0];
    endfunction

    // advances the ring state by one request and returns its result
    function automatic t_result ring_response(t_req req, logic [SAMPLE_BITS-1:0] smp,
                                              logic bs);
        t_result          r;
        logic [CNT_W-1:0] lvl;
        r = '0;
        lvl = wr_cnt - rd_cnt;
        case (req)
            REQ_PUSH: begin
                n_push++;
                if (lvl < RING_DEPTH) begin
                    ring_mem[wr_cnt[ADDR_W-1:0]] = smp;
                    wr_cnt = wr_cnt + 1'b1;
                    r.accepted = 1'b1;
                end else begin
                    n_drop++;
                end
            end
            REQ_PULL: begin
                n_pull++;
                if (bs) begin
                    silenced = 1'b0;
                    if (flush_pend) begin
                        rd_cnt = wr_cnt;
                        flush_pend = 1'b0;
                        silenced = 1'b1;
                    end
                end
                if (silenced || wr_cnt == rd_cnt) begin
                    r.underrun = 1'b1;
                    n_under++;
                end else begin
                    r.sample = scale_by_gain(ring_mem[rd_cnt[ADDR_W-1:0]],
                                             mute_on ? '0 : gain_q15);
                    rd_cnt = rd_cnt + 1'b1;
                end
            end
            REQ_FLUSH: begin
                n_flush++;
                flush_pend = 1'b1;
            end
            default: n_noop++;
        endcase
        return r;
    endfunction

    task automatic add_row(t_req req, logic [SAMPLE_BITS-1:0] smp, logic bs, logic typed,
                           logic [SAMPLE_BITS-1:0] e_smp, logic e_und, logic e_acc);
        t_row row;
        row.req = req;
        row.sample = smp;
        row.blk_start = bs;
        row.typed = typed;
        row.res = '{e_smp, e_und, e_acc};
        dir_rows.push_back(row);
    endtask

    task automatic idle_sender(int n);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 6);
            if (gap != 0) idle_sender(gap);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(1, 24);
        end
    endtask

    task automatic send_request(t_req req, logic [SAMPLE_BITS-1:0] smp, logic bs,
                                logic typed, t_result typed_res);
        t_result r;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_req_type = req;
        i_sample_in = smp;
        i_block_start = bs;
        do @(posedge i_clk); while (o_in_stall);
        r = ring_response(req, smp, bs);
        awaited_results.push_back(typed ? typed_res : r);
        pace_sender();
    endtask

    // hold the sender until the output side has caught up
    task automatic wait_all_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        n_cfg++;
        if (idx == CFG_GAIN) gain_q15 = (data > GAIN_ONE) ? GAIN_ONE : data;
        else if (idx == CFG_MUTE) mute_on = data[0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] s;
        s = SAMPLE_BITS'($urandom);
        if ($urandom_range(0, 15) == 0) s = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        return s;
    endfunction

    // mostly pushes and pulls grouped in output blocks, with flushes, idle codes and
    // pulls whose block marking is random
    task automatic run_random(int n_items, int push_pct);
        int                     k;
        int                     pick;
        t_req                   rq;
        logic [SAMPLE_BITS-1:0] smp;
        logic                   bs;
        for (k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            smp = pick_sample();
            bs = 1'($urandom_range(0, 1));
            if (pick < push_pct) begin
                rq = REQ_PUSH;
            end else if (pick < 88) begin
                rq = REQ_PULL;
                bs = (blk_left == 0);
                if (blk_left == 0) blk_left = $urandom_range(1, 8);
                blk_left--;
            end else if (pick < 93) begin
                rq = REQ_FLUSH;
            end else if (pick < 96) begin
                rq = REQ_NONE;
            end else begin
                rq = REQ_PULL;
            end
            send_request(rq, smp, bs, 1'b0, '0);
            if ($urandom_range(0, 199) == 0) wait_all_results();
        end
    endtask

    // receiver backpressure: a new stall mode for each random window
    initial begin
        t_stall_mode mode;
        int          win;
        int          tick;
        i_out_stall = 1'b0;
        mode = STALL_OFF;
        win = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            if (win == 0) begin
                mode = t_stall_mode'($urandom_range(0, 3));
                win = $urandom_range(16, 96);
            end
            win--;
            tick++;
            case (mode)
                STALL_OFF:   i_out_stall = 1'b0;
                STALL_LIGHT: i_out_stall = ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall = ($urandom_range(0, 3) != 0);
                default:     i_out_stall = (tick % 5) < 2;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("result with no request awaiting it: sample %0d underrun %b accepted %b",
                             $signed(o_sample_out), o_underrun, o_push_accepted);
            end else begin
                want = awaited_results.pop_front();
                if (o_sample_out !== want.sample || o_underrun !== want.underrun ||
                    o_push_accepted !== want.accepted) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected %0d/%b/%b got %0d/%b/%b",
                                 $signed(want.sample), want.underrun, want.accepted,
                                 $signed(o_sample_out), o_underrun, o_push_accepted);
                end
            end
        end
    end

    initial begin
        int   k;
        t_row row;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = REQ_NONE;
        i_sample_in = '0;
        i_block_start = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_GAIN;
        i_cfg_data = '0;
        wr_cnt = '0;
        rd_cnt = '0;
        flush_pend = 1'b0;
        silenced = 1'b0;
        gain_q15 = GAIN_ONE;
        mute_on = 1'b0;
        mismatch_cnt = 0;
        burst_left = 0;
        blk_left = 0;
        {n_push, n_pull, n_flush, n_noop, n_drop, n_under, n_cfg} = '0;

        // reset state: empty ring, unity gain
        add_row(REQ_PULL,  16'h0000, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b0);
        add_row(REQ_NONE,  16'hFFFF, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0);
        add_row(REQ_PUSH,  16'h7FFF, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b1);
        add_row(REQ_PUSH,  16'h8000, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b1);
        add_row(REQ_PUSH,  16'h0000, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1);
        add_row(REQ_PUSH,  16'hFFFF, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b1);
        add_row(REQ_PULL,  16'h0000, 1'b1, 1'b1, 16'h7FFF, 1'b0, 1'b0);
        add_row(REQ_PULL,  16'hFFFF, 1'b0, 1'b1, 16'h8000, 1'b0, 1'b0);
        add_row(REQ_PULL,  16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0);
        add_row(REQ_PULL,  16'h0000, 1'b0, 1'b1, 16'hFFFF, 1'b0, 1'b0);
        add_row(REQ_PULL,  16'h0000, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b0);
        add_row(REQ_PUSH,  16'h1234, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(REQ_PUSH,  16'hEDCB, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        // flush waits for the next block start
        add_row(REQ_FLUSH, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0);
        add_row(REQ_PULL,  16'h0000, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(REQ_PULL,  16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0);
        add_row(REQ_PUSH,  16'h0064, 1'b0, 1'b0, '0, 1'b0, 1'b0);
        add_row(REQ_PULL,  16'h0000, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b0);
        add_row(REQ_PULL,  16'h0000, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        add_row(REQ_PULL,  16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0);
        add_row(REQ_FLUSH, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0);
        add_row(REQ_FLUSH, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0);
        add_row(REQ_PULL,  16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0);
        add_row(REQ_PULL,  16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0);
        add_row(REQ_NONE,  16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (k = 0; k < dir_rows.size(); k++) begin
            row = dir_rows[k];
            send_request(row.req, row.sample, row.blk_start, row.typed, row.res);
        end
        wait_all_results();

        // gain write above unity saturates
        write_reg(CFG_GAIN, 16'hFFFF);
        write_reg(CFG_MUTE, 16'h0000);
        run_random(200, 45);
        wait_all_results();

        write_reg(CFG_GAIN, 16'h0000);
        run_random(150, 50);
        wait_all_results();

        write_reg(CFG_GAIN, 16'h0001);
        write_reg(CFG_MUTE, 16'h0001);
        run_random(150, 45);
        wait_all_results();

        write_reg(CFG_MUTE, 16'hFFFE);
        write_reg(CFG_GAIN, GAIN_W'($urandom_range(1, 32767)));
        write_reg(CFG_SPARE, 16'h0000);
        run_random(200, 55);
        wait_all_results();

        write_reg(CFG_GAIN, 16'h8001);
        run_random(200, 40);
        wait_all_results();

        write_reg(CFG_GAIN, 16'h4000);
        run_random(200, 50);
        wait_all_results();
        repeat (20) @(posedge i_clk);

        mismatch_cnt += awaited_results.size();
        $display("run: %0d pushes (%0d dropped on a full ring), %0d pulls (%0d underruns)",
                 n_push, n_drop, n_pull, n_under);
        $display("     %0d flushes, %0d unused codes, %0d register writes, %0d failures",
                 n_flush, n_noop, n_cfg, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("tb_audio_ring_fifo_with_volume_top OK");
        end else begin
            $display("tb_audio_ring_fifo_with_volume_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/arfv_pkg.sv
sv/arfv_ram.sv
sv/arfv_ctrl.sv
sv/arfv_out.sv
sv/audio_ring_fifo_with_volume_top.sv
test/tb_audio_ring_fifo_with_volume_top.sv
